FILE: rtl/qmsd_pkg.sv
package qmsd_pkg;

  localparam int COMP_W    = 16;
  localparam int TIME_W    = 32;
  localparam int THR_W     = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int NUM_LANES = 4;

  typedef logic [COMP_W-1:0]                 comp_t;
  typedef comp_t [NUM_LANES-1:0]             quat_t;
  typedef logic [TIME_W-1:0]                 time_t;
  typedef logic [1:0]                        event_t;

  // result codes
  localparam event_t EV_NONE  = 2'd0;
  localparam event_t EV_MOVE  = 2'd1;
  localparam event_t EV_STILL = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL_TIMEOUT    = 1'd1;

  localparam logic [THR_W-1:0]  THR_RESET     = 16'd16;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd5000;

  // per-transaction control handed to the merge stage
  typedef struct packed {
    logic take;
    logic is_rv;
  } step_ctl_t;

endpackage

FILE: rtl/qmsd_in_if.sv
interface qmsd_in_if import qmsd_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  is_rotation_vector;
  comp_t quat_i;
  comp_t quat_j;
  comp_t quat_k;
  comp_t quat_real;
  time_t now_ms;

  modport source (
    output valid, is_rotation_vector, quat_i, quat_j, quat_k, quat_real, now_ms,
    input  ready
  );
  modport sink (
    input  valid, is_rotation_vector, quat_i, quat_j, quat_k, quat_real, now_ms,
    output ready
  );
endinterface

FILE: rtl/qmsd_out_if.sv
interface qmsd_out_if import qmsd_pkg::*; ();
  logic   valid;
  logic   ready;
  event_t event_res;

  modport source (output valid, event_res, input ready);
  modport sink (input valid, event_res, output ready);
endinterface

FILE: rtl/qmsd_lane.sv
module qmsd_lane import qmsd_pkg::*; (
  input  comp_t             cur,
  input  comp_t             prev,
  input  logic [THR_W-1:0]  thr,
  output logic              exceed
);

  logic [COMP_W:0] diff;
  logic [COMP_W:0] mag;

  // exact 17-bit signed difference, then magnitude
  assign diff   = {cur[COMP_W-1], cur} - {prev[COMP_W-1], prev};
  assign mag    = diff[COMP_W] ? (~diff + 1'b1) : diff;
  assign exceed = mag > {1'b0, thr};

endmodule

FILE: rtl/qmsd_merge.sv
module qmsd_merge import qmsd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  step_ctl_t            ctl,
  input  quat_t                quat,
  input  time_t                now_ms,
  input  time_t                timeout,
  input  logic [NUM_LANES-1:0] exceed,
  output quat_t                prev_quat,
  output event_t               event_res
);

  logic   awaiting_first_r, awaiting_first_nxt;
  logic   is_still_r, is_still_nxt;
  time_t  last_motion_r, last_motion_nxt;
  quat_t  prev_quat_r;
  time_t  elapsed;
  logic   motion;

  assign motion    = |exceed;
  assign elapsed   = now_ms - last_motion_r;
  assign prev_quat = prev_quat_r;

  always_comb begin
    awaiting_first_nxt = awaiting_first_r;
    is_still_nxt       = is_still_r;
    last_motion_nxt    = last_motion_r;
    event_res          = EV_NONE;
    if (ctl.is_rv) begin
      if (awaiting_first_r) begin
        awaiting_first_nxt = 1'b0;
        last_motion_nxt    = now_ms;
      end else if (motion) begin
        last_motion_nxt = now_ms;
        if (is_still_r) begin
          is_still_nxt = 1'b0;
          event_res    = EV_MOVE;
        end
      end else if (!is_still_r && (elapsed > timeout)) begin
        is_still_nxt = 1'b1;
        event_res    = EV_STILL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_first_r <= 1'b1;
      is_still_r       <= 1'b0;
    end else if (ctl.take && ctl.is_rv) begin
      awaiting_first_r <= awaiting_first_nxt;
      is_still_r       <= is_still_nxt;
    end
  end

  // payload state, only meaningful once the first report is stored
  always_ff @(posedge clk) begin
    if (ctl.take && ctl.is_rv) begin
      last_motion_r <= last_motion_nxt;
      prev_quat_r   <= quat;
    end
  end

endmodule

FILE: rtl/quaternion_motion_stillness_detector.sv
// result: registered into the output register, or into the skid entry while out_ch stalls
// throughput: one transaction per cycle unless the skid entry is full; four component lanes
//   and the timeout compare all settle in the accept cycle
// a two-entry output buffer (output register plus skid) keeps in_ch open while a result waits
// reset: rst_n is synchronous, active low; it clears control state and loads register defaults
module quaternion_motion_stillness_detector import qmsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  qmsd_in_if.sink               in_ch,
  qmsd_out_if.source            out_ch
);

  // configuration registers
  logic [THR_W-1:0] thr_r;
  time_t            timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THR_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MOTION_THRESHOLD: thr_r     <= cfg_wdata[THR_W-1:0];
        CFG_STILL_TIMEOUT:    timeout_r <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // input side
  logic                 accept;
  step_ctl_t            ctl;
  quat_t                quat;
  quat_t                prev_quat;
  logic [NUM_LANES-1:0] exceed;
  event_t               ev;

  assign accept    = in_ch.valid && in_ch.ready;
  assign ctl.take  = accept;
  assign ctl.is_rv = in_ch.is_rotation_vector;

  // lane order i, j, k, real
  assign quat[0] = in_ch.quat_i;
  assign quat[1] = in_ch.quat_j;
  assign quat[2] = in_ch.quat_k;
  assign quat[3] = in_ch.quat_real;

  // one lane per component: magnitude of change against threshold
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    qmsd_lane u_lane (
      .cur    (quat[g]),
      .prev   (prev_quat[g]),
      .thr    (thr_r),
      .exceed (exceed[g])
    );
  end

  // merge lane flags with the motion/stillness state
  qmsd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .quat      (quat),
    .now_ms    (in_ch.now_ms),
    .timeout   (timeout_r),
    .exceed    (exceed),
    .prev_quat (prev_quat),
    .event_res (ev)
  );

  // output register with skid entry
  logic   ov_r, ov_nxt;
  logic   sv_r, sv_nxt;
  event_t od_r, od_nxt;
  event_t sd_r, sd_nxt;

  assign in_ch.ready      = !sv_r;
  assign out_ch.valid     = ov_r;
  assign out_ch.event_res = od_r;

  always_comb begin
    ov_nxt = ov_r;
    od_nxt = od_r;
    sv_nxt = sv_r;
    sd_nxt = sd_r;
    if (!ov_r || out_ch.ready) begin
      if (sv_r) begin
        // drain the skid entry first
        ov_nxt = 1'b1;
        od_nxt = sd_r;
        sv_nxt = 1'b0;
      end else begin
        ov_nxt = accept;
        od_nxt = ev;
      end
    end else if (accept) begin
      // output stalled: park the new result
      sv_nxt = 1'b1;
      sd_nxt = ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      sv_r <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
    sd_r <= sd_nxt;
  end

endmodule

FILE: rtl/qmsd_checker.sv
module qmsd_checker import qmsd_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input event_t out_event
);

  event_t ev_last_r;
  logic   out_xfer;

  assign out_xfer = out_valid && out_ready;

  // last nonzero event delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_last_r <= EV_NONE;
    end else if (out_xfer && (out_event != EV_NONE)) begin
      ev_last_r <= out_event;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event))
    else $error("result dropped or changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event == EV_NONE || out_event == EV_MOVE || out_event == EV_STILL))
    else $error("undefined event code");

  a_alternate: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && (out_event != EV_NONE) |-> out_event != ev_last_r)
    else $error("movement and stillness events do not alternate");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

endmodule

bind quaternion_motion_stillness_detector qmsd_checker u_qmsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_event (out_ch.event_res)
);
